// ===== src/m51alu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m51alu_pkg: shared types and constants of the 8051 byte ALU
// Operation codes, the stage record that travels down the pipeline and the
// divider split.
// ----------------------------------------------------------------------------
package m51alu_pkg;

  // Width of the divider data path (quotient bits to resolve)
  localparam int unsigned DivWidth = 8;

  // Restoring divide steps done in each divider stage
  localparam int unsigned DivStepsDefault = 2;

  // BCD adjust constants
  localparam logic [3:0] BcdMaxDigit = 4'd9;
  localparam logic [7:0] BcdLowFix   = 8'h06;
  localparam logic [7:0] BcdHighFix  = 8'h60;

  typedef enum logic [3:0] {
    OpAdd  = 4'd0,
    OpAddc = 4'd1,
    OpSubb = 4'd2,
    OpOrl  = 4'd3,
    OpAnl  = 4'd4,
    OpXrl  = 4'd5,
    OpInc  = 4'd6,
    OpDec  = 4'd7,
    OpDiv  = 4'd8,
    OpDa   = 4'd9,
    OpSwap = 4'd10,
    OpCpl  = 4'd11,
    OpClr  = 4'd12,
    OpXchd = 4'd13,
    OpCjne = 4'd14,
    OpDjnz = 4'd15
  } op_e;

  // One item in flight: finished result for the simple operations plus the
  // running divider state
  typedef struct packed {
    op_e                 op;
    logic [7:0]          acc;
    logic [7:0]          bval;
    logic                cy;
    logic                ac;
    logic                ov;
    logic                br;
    logic                div_en;
    logic [DivWidth-1:0] rem;
    logic [DivWidth-1:0] quo;
    logic [DivWidth-1:0] dvsr;
  } pipe_t;

endpackage

// ===== src/m51alu_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m51alu_front: operation decode and the arithmetic of the simple operations
// Computes every operation except the divide loop and registers the item,
// seeding the divider state for DIV with a nonzero divisor.
// ----------------------------------------------------------------------------
module m51alu_front import m51alu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] operation_i,
  input  logic [7:0] acc_in_i,
  input  logic [7:0] operand_in_i,
  input  logic [7:0] b_in_i,
  input  logic       carry_in_i,
  input  logic       aux_in_i,
  input  logic       ovf_in_i,
  output logic       out_valid_o,
  output pipe_t      out_data_o,
  input  logic       out_stall_i
);

  pipe_t      res_d, res_q;
  logic       valid_q;
  logic [8:0] sum9;
  logic [4:0] nib5;
  logic [8:0] da9;
  logic [7:0] da_t;
  logic       da_cy;
  logic       cin;

  assign in_stall_o = valid_q && out_stall_i;

  // Result of the item at the input
  always_comb begin
    res_d        = '0;
    res_d.op     = op_e'(operation_i);
    res_d.acc    = acc_in_i;
    res_d.bval   = operand_in_i;
    res_d.cy     = carry_in_i;
    res_d.ac     = aux_in_i;
    res_d.ov     = ovf_in_i;
    res_d.br     = 1'b0;
    res_d.div_en = 1'b0;
    res_d.rem    = '0;
    res_d.quo    = acc_in_i;
    res_d.dvsr   = b_in_i;
    sum9         = '0;
    nib5         = '0;
    da9          = '0;
    da_t         = '0;
    da_cy        = 1'b0;
    cin          = (op_e'(operation_i) == OpAdd) ? 1'b0 : carry_in_i;

    unique case (op_e'(operation_i))
      OpAdd, OpAddc: begin
        sum9      = {1'b0, acc_in_i} + {1'b0, operand_in_i} + {8'd0, cin};
        nib5      = {1'b0, acc_in_i[3:0]} + {1'b0, operand_in_i[3:0]} + {4'd0, cin};
        res_d.acc = sum9[7:0];
        res_d.cy  = sum9[8];
        res_d.ac  = nib5[4];
        res_d.ov  = (acc_in_i[7] ^ sum9[7]) & (operand_in_i[7] ^ sum9[7]);
      end
      OpSubb: begin
        // borrow out of the ninth bit
        sum9      = {1'b0, acc_in_i} - {1'b0, operand_in_i} - {8'd0, carry_in_i};
        nib5      = {1'b0, acc_in_i[3:0]} - {1'b0, operand_in_i[3:0]}
                    - {4'd0, carry_in_i};
        res_d.acc = sum9[7:0];
        res_d.cy  = sum9[8];
        res_d.ac  = nib5[4];
        res_d.ov  = (acc_in_i[7] ^ operand_in_i[7]) & (acc_in_i[7] ^ sum9[7]);
      end
      OpOrl: res_d.acc = acc_in_i | operand_in_i;
      OpAnl: res_d.acc = acc_in_i & operand_in_i;
      OpXrl: res_d.acc = acc_in_i ^ operand_in_i;
      OpInc: res_d.bval = operand_in_i + 8'd1;
      OpDec: res_d.bval = operand_in_i - 8'd1;
      OpDiv: begin
        // divide by zero leaves A and B, sets OV
        res_d.cy     = 1'b0;
        res_d.ov     = (b_in_i == 8'd0);
        res_d.bval   = b_in_i;
        res_d.div_en = (b_in_i != 8'd0);
      end
      OpDa: begin
        da_t  = acc_in_i;
        da_cy = carry_in_i;
        if (da_t[3:0] > BcdMaxDigit || aux_in_i) begin
          da9   = {1'b0, da_t} + {1'b0, BcdLowFix};
          da_cy = da_cy | da9[8];
          da_t  = da9[7:0];
        end
        if (da_t[7:4] > BcdMaxDigit || da_cy) begin
          da9   = {1'b0, da_t} + {1'b0, BcdHighFix};
          da_cy = da_cy | da9[8];
          da_t  = da9[7:0];
        end
        res_d.acc = da_t;
        res_d.cy  = da_cy;
      end
      OpSwap: res_d.acc = {acc_in_i[3:0], acc_in_i[7:4]};
      OpCpl:  res_d.acc = ~acc_in_i;
      OpClr:  res_d.acc = 8'd0;
      OpXchd: begin
        res_d.bval = {operand_in_i[7:4], acc_in_i[3:0]};
        res_d.acc  = {acc_in_i[7:4], operand_in_i[3:0]};
      end
      OpCjne: begin
        res_d.br = (acc_in_i != operand_in_i);
        res_d.cy = (acc_in_i < operand_in_i);
      end
      OpDjnz: begin
        res_d.bval = operand_in_i - 8'd1;
        res_d.br   = (operand_in_i != 8'd1);
      end
    endcase
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = res_q;

endmodule

// ===== src/m51alu_div_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m51alu_div_stage: one stage of the restoring divider
// Resolves STEPS quotient bits of the item and registers it. Items that do
// not divide pass through unchanged.
// ----------------------------------------------------------------------------
module m51alu_div_stage import m51alu_pkg::*; #(
  parameter int unsigned STEPS = DivStepsDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  pipe_t in_data_i,
  output logic  out_valid_o,
  output pipe_t out_data_o,
  input  logic  out_stall_i
);

  pipe_t data_d, data_q;
  logic  valid_q;

  assign in_stall_o = valid_q && out_stall_i;

  // Shift-subtract steps
  always_comb begin
    logic [DivWidth:0] rem_sh;
    logic              qbit;
    data_d = in_data_i;
    rem_sh = '0;
    qbit   = 1'b0;
    if (in_data_i.div_en) begin
      for (int k = 0; k < STEPS; k++) begin
        rem_sh = {data_d.rem, data_d.quo[DivWidth-1]};
        qbit   = (rem_sh >= {1'b0, data_d.dvsr});
        if (qbit) begin
          rem_sh = rem_sh - {1'b0, data_d.dvsr};
        end
        data_d.rem = rem_sh[DivWidth-1:0];
        data_d.quo = {data_d.quo[DivWidth-2:0], qbit};
      end
    end
  end

  // Stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ===== src/mcs51_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs51_alu: pipelined byte ALU of an 8051 core
// ADD/ADDC/SUBB, logic ops, INC/DEC/DJNZ, DIV, DA, SWAP, CPL, CLR, XCHD and
// CJNE with the PSW flag updates.
//
//  channel | handshake                | payload
//  --------+--------------------------+---------------------------------------
//  in      | in_valid_i / in_stall_o  | operation, acc, operand, b, cy/ac/ov
//  out     | out_valid_o / out_stall_i| acc, byte, cy/ac/ov, branch_taken
//
// One item enters per cycle while the input is not stalled; the front stage
// register is followed by the restoring divider stages, DIV_STEPS bits per stage.
// Every item, dividing or not, takes the same path, so order is kept.
// Each stage holds its item while the stage after it is full and stalled;
// empty stages keep filling, so the block takes items while a result waits.
// Reset only clears the stage valid bits.
// ----------------------------------------------------------------------------
module mcs51_alu import m51alu_pkg::*; #(
  parameter int unsigned DIV_STEPS = DivStepsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [3:0] operation_i,
  input  logic [7:0] acc_in_i,
  input  logic [7:0] operand_in_i,
  input  logic [7:0] b_in_i,
  input  logic       carry_in_i,
  input  logic       aux_in_i,
  input  logic       ovf_in_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] acc_out_o,
  output logic [7:0] byte_out_o,
  output logic       carry_out_o,
  output logic       aux_out_o,
  output logic       ovf_out_o,
  output logic       branch_taken_o
);

  localparam int unsigned NumDivStages = DivWidth / DIV_STEPS;

  logic  c_valid [NumDivStages+1];
  logic  c_stall [NumDivStages+1];
  pipe_t c_data  [NumDivStages+1];
  pipe_t last;

  // Decode and simple operations
  m51alu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .operation_i  (operation_i),
    .acc_in_i     (acc_in_i),
    .operand_in_i (operand_in_i),
    .b_in_i       (b_in_i),
    .carry_in_i   (carry_in_i),
    .aux_in_i     (aux_in_i),
    .ovf_in_i     (ovf_in_i),
    .out_valid_o  (c_valid[0]),
    .out_data_o   (c_data[0]),
    .out_stall_i  (c_stall[0])
  );

  // Divider stages
  for (genvar g = 0; g < NumDivStages; g++) begin : g_div
    m51alu_div_stage #(
      .STEPS (DIV_STEPS)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (c_valid[g]),
      .in_stall_o  (c_stall[g]),
      .in_data_i   (c_data[g]),
      .out_valid_o (c_valid[g+1]),
      .out_data_o  (c_data[g+1]),
      .out_stall_i (c_stall[g+1])
    );
  end

  assign c_stall[NumDivStages] = out_stall_i;
  assign last                  = c_data[NumDivStages];

  // Result select: quotient and remainder for a real divide
  assign out_valid_o    = c_valid[NumDivStages];
  assign acc_out_o      = last.div_en ? last.quo : last.acc;
  assign byte_out_o     = last.div_en ? last.rem : last.bval;
  assign carry_out_o    = last.cy;
  assign aux_out_o      = last.ac;
  assign ovf_out_o      = last.ov;
  assign branch_taken_o = last.br;

  // Checks
  a_div_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last.div_en |-> last.rem < last.dvsr)
    else $error("divide remainder not below divisor");

  a_div_clears_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last.op == OpDiv |-> !carry_out_o && (ovf_out_o == !last.div_en))
    else $error("divide flags wrong");

  a_branch_only_cjne_djnz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && branch_taken_o |-> last.op == OpCjne || last.op == OpDjnz)
    else $error("branch flag on non-branch operation");

  a_empty_front_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !c_valid[0] |-> !in_stall_o)
    else $error("input stalled with empty first stage");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the mcs51_alu byte ALU
// Sends ALU items through the valid/stall input channel and checks every
// result against a behavioral model of the 8051 arithmetic and flag rules.
// The sender works in bursts and the receiver stalls on a changing pattern.
// One long receiver hold-off fills the pipeline until it stalls its input.
// ----------------------------------------------------------------------------
module tb;
  import m51alu_pkg::*;

  localparam int unsigned IdleLimit  = 1000;  // cycles with no item moving
  localparam int unsigned DrainWait  = 16;    // extra wait after the last expected result
  localparam int unsigned HoldCycles = 48;    // long receiver hold-off
  localparam int unsigned MaxPrinted = 50;

  typedef enum int unsigned {RxFree, RxRandom, RxMostly, RxAlternate} rx_mode_e;

  // One ALU item as it enters the block
  typedef struct packed {
    op_e        op;
    logic [7:0] acc;
    logic [7:0] opnd;
    logic [7:0] bval;
    logic       cy;
    logic       ac;
    logic       ov;
  } alu_in_t;

  // One ALU result
  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] bval;
    logic       cy;
    logic       ac;
    logic       ov;
    logic       br;
  } alu_res_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [3:0] operation_i;
  logic [7:0] acc_in_i;
  logic [7:0] operand_in_i;
  logic [7:0] b_in_i;
  logic       carry_in_i;
  logic       aux_in_i;
  logic       ovf_in_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] acc_out_o;
  logic [7:0] byte_out_o;
  logic       carry_out_o;
  logic       aux_out_o;
  logic       ovf_out_o;
  logic       branch_taken_o;

  alu_res_t    alu_pending[$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  bit          gaps_on     = 1'b1;
  int unsigned hold_asked  = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned mode_left   = 0;
  int unsigned rx_phase    = 0;
  rx_mode_e    rx_mode     = RxFree;

  mcs51_alu dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .operation_i   (operation_i),
    .acc_in_i      (acc_in_i),
    .operand_in_i  (operand_in_i),
    .b_in_i        (b_in_i),
    .carry_in_i    (carry_in_i),
    .aux_in_i      (aux_in_i),
    .ovf_in_i      (ovf_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .acc_out_o     (acc_out_o),
    .byte_out_o    (byte_out_o),
    .carry_out_o   (carry_out_o),
    .aux_out_o     (aux_out_o),
    .ovf_out_o     (ovf_out_o),
    .branch_taken_o(branch_taken_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ALU behavior: new accumulator, second byte, flags and branch condition
  function automatic alu_res_t alu_result(alu_in_t x);
    alu_res_t   r;
    logic       cin;
    logic [8:0] sum;
    logic [4:0] nib;
    logic [9:0] adj;
    r.acc  = x.acc;
    r.bval = x.opnd;
    r.cy   = x.cy;
    r.ac   = x.ac;
    r.ov   = x.ov;
    r.br   = 1'b0;
    case (x.op)
      OpAdd, OpAddc: begin
        cin   = (x.op == OpAddc) ? x.cy : 1'b0;
        sum   = {1'b0, x.acc} + {1'b0, x.opnd} + 9'(cin);
        nib   = {1'b0, x.acc[3:0]} + {1'b0, x.opnd[3:0]} + 5'(cin);
        r.acc = sum[7:0];
        r.cy  = sum[8];
        r.ac  = nib[4];
        r.ov  = (x.acc[7] ^ r.acc[7]) & (x.opnd[7] ^ r.acc[7]);
      end
      OpSubb: begin
        r.acc = x.acc - x.opnd - 8'(x.cy);
        r.cy  = ({1'b0, x.opnd} + 9'(x.cy)) > {1'b0, x.acc};
        r.ac  = ({1'b0, x.opnd[3:0]} + 5'(x.cy)) > {1'b0, x.acc[3:0]};
        r.ov  = (x.acc[7] ^ x.opnd[7]) & (x.acc[7] ^ r.acc[7]);
      end
      OpOrl:  r.acc = x.acc | x.opnd;
      OpAnl:  r.acc = x.acc & x.opnd;
      OpXrl:  r.acc = x.acc ^ x.opnd;
      OpInc:  r.bval = x.opnd + 8'd1;
      OpDec:  r.bval = x.opnd - 8'd1;
      OpDiv: begin
        r.cy = 1'b0;
        if (x.bval == 8'd0) begin
          // divide by zero leaves A and B as they were
          r.ov   = 1'b1;
          r.bval = x.bval;
        end else begin
          r.ov   = 1'b0;
          r.acc  = x.acc / x.bval;
          r.bval = x.acc % x.bval;
        end
      end
      OpDa: begin
        adj = {2'b00, x.acc};
        if (adj[3:0] > BcdMaxDigit || x.ac) begin
          adj = adj + 10'(BcdLowFix);
          if (adj[8]) r.cy = 1'b1;
          adj = {2'b00, adj[7:0]};
        end
        if (adj[7:4] > BcdMaxDigit || r.cy) begin
          adj = adj + 10'(BcdHighFix);
          if (adj[8]) r.cy = 1'b1;
        end
        r.acc = adj[7:0];
      end
      OpSwap: r.acc = {x.acc[3:0], x.acc[7:4]};
      OpCpl:  r.acc = ~x.acc;
      OpClr:  r.acc = 8'd0;
      OpXchd: begin
        r.bval = {x.opnd[7:4], x.acc[3:0]};
        r.acc  = {x.acc[7:4], x.opnd[3:0]};
      end
      OpCjne: begin
        r.br = (x.acc != x.opnd);
        r.cy = (x.acc < x.opnd);
      end
      default: begin
        r.bval = x.opnd - 8'd1;
        r.br   = (r.bval != 8'd0);
      end
    endcase
    return r;
  endfunction

  function automatic alu_in_t alu_item(op_e op, logic [7:0] a, logic [7:0] v,
                                       logic [7:0] b, logic cy, logic ac, logic ov);
    alu_in_t x;
    x.op   = op;
    x.acc  = a;
    x.opnd = v;
    x.bval = b;
    x.cy   = cy;
    x.ac   = ac;
    x.ov   = ov;
    return x;
  endfunction

  // byte with a bias toward the edges of the range
  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 11))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h7F;
      3:       return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic alu_in_t random_item();
    alu_in_t x;
    x = alu_item(op_e'($urandom_range(0, 15)), edgy_byte(), edgy_byte(),
                 edgy_byte(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)));
    if (x.op == OpDiv && $urandom_range(0, 5) == 0) x.bval = 8'd0;
    if (x.op == OpCjne && $urandom_range(0, 3) == 0) x.opnd = x.acc;
    if (x.op == OpDjnz && $urandom_range(0, 3) == 0) x.opnd = 8'd1;
    return x;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < MaxPrinted)
      $display("%0t ns: %s: got %02h, want %02h", $time, what, got, want);
    mismatches++;
  endtask

  // Send one item; gaps between bursts are decided before valid goes up
  task automatic send_item(input alu_in_t x);
    int unsigned gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= x.op;
    acc_in_i     <= x.acc;
    operand_in_i <= x.opnd;
    b_in_i       <= x.bval;
    carry_in_i   <= x.cy;
    aux_in_i     <= x.ac;
    ovf_in_i     <= x.ov;
    do @(posedge clk_i); while (in_stall_o);
    alu_pending.push_back(alu_result(x));
  endtask

  // Arithmetic at the edges: carries, half carries, overflow, borrow
  task automatic test_arith_edges();
    send_item(alu_item(OpAdd,  8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OpAddc, 8'h7F, 8'h00, 8'hFF, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OpAddc, 8'h80, 8'h80, 8'h00, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OpSubb, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OpSubb, 8'h80, 8'h01, 8'h00, 1'b0, 1'b1, 1'b0));
  endtask

  // Logic, count and exchange operations
  task automatic test_logic_and_count();
    send_item(alu_item(OpOrl,  8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpAnl,  8'hFF, 8'hAA, 8'h00, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OpXrl,  8'h55, 8'hFF, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(alu_item(OpInc,  8'h3C, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1));
    send_item(alu_item(OpDec,  8'hC3, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(alu_item(OpSwap, 8'hA5, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpCpl,  8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OpClr,  8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1));
    send_item(alu_item(OpXchd, 8'h12, 8'h34, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpCjne, 8'h5A, 8'h5A, 8'h00, 1'b1, 1'b0, 1'b0));
    send_item(alu_item(OpCjne, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpDjnz, 8'h00, 8'h01, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpDjnz, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 1'b1));
  endtask

  // Division including divide by zero with CY set and OV clear beforehand
  task automatic test_divide();
    send_item(alu_item(OpDiv, 8'hAB, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0));
    send_item(alu_item(OpDiv, 8'hFF, 8'h00, 8'h01, 1'b1, 1'b0, 1'b1));
    send_item(alu_item(OpDiv, 8'hFE, 8'hFF, 8'h10, 1'b0, 1'b0, 1'b1));
  endtask

  // Decimal adjust: low digit fix, high digit fix, carry kept, carry out
  task automatic test_decimal_adjust();
    send_item(alu_item(OpDa, 8'h9A, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0));
    send_item(alu_item(OpDa, 8'h0F, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
    send_item(alu_item(OpDa, 8'h99, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1));
    send_item(alu_item(OpDa, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b1, 1'b0));
  endtask

  // Receiver holds off while the sender keeps offering items back to back
  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_asked <= hold_asked + 1;
    repeat (30) send_item(random_item());
    gaps_on = 1'b1;
  endtask

  task automatic test_random(input int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  // Receiver stall pattern, with the long hold-off when one is asked for
  always @(posedge clk_i) begin
    logic stall_now;
    if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HoldCycles;
    end
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(16, 80);
    end
    mode_left--;
    rx_phase++;
    case (rx_mode)
      RxFree:   stall_now = 1'b0;
      RxRandom: stall_now = ($urandom_range(0, 2) == 0);
      RxMostly: stall_now = (rx_phase[1:0] != 2'd0);
      default:  stall_now = rx_phase[0];
    endcase
    if (hold_left > 0) begin
      stall_now = 1'b1;
      hold_left--;
    end
    out_stall_i <= stall_now;
  end

  // Result check against the oldest pending expectation
  always @(posedge clk_i) begin
    alu_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (alu_pending.size() == 0) begin
        report_mismatch("result with none pending, acc_out", acc_out_o, 0);
      end else begin
        want = alu_pending.pop_front();
        if (acc_out_o != want.acc)      report_mismatch("acc_out", acc_out_o, want.acc);
        if (byte_out_o != want.bval)    report_mismatch("byte_out", byte_out_o, want.bval);
        if (carry_out_o != want.cy)     report_mismatch("carry_out", carry_out_o, want.cy);
        if (aux_out_o != want.ac)       report_mismatch("aux_out", aux_out_o, want.ac);
        if (ovf_out_o != want.ov)       report_mismatch("ovf_out", ovf_out_o, want.ov);
        if (branch_taken_o != want.br)  report_mismatch("branch_taken", branch_taken_o, want.br);
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("timeout: nothing moved for %0d cycles", IdleLimit);
      $display("mcs51_alu: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    operation_i  <= OpAdd;
    acc_in_i     <= 8'h00;
    operand_in_i <= 8'h00;
    b_in_i       <= 8'h00;
    carry_in_i   <= 1'b0;
    aux_in_i     <= 1'b0;
    ovf_in_i     <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_arith_edges();
    test_logic_and_count();
    test_divide();
    test_decimal_adjust();
    test_random(200);
    test_backpressure();
    test_random(290);

    in_valid_i <= 1'b0;
    while (alu_pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mcs51_alu: match");
    end else begin
      $display("mcs51_alu: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/m51alu_pkg.sv
src/m51alu_front.sv
src/m51alu_div_stage.sv
src/mcs51_alu.sv
sim/tb.sv
